// ===== rtl/sdf_pkg.sv =====
// Package for the stream duplicate filter: shared widths, controller state
// type and the command/status structs between controller and datapath.
// No dependencies.
package sdf_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } sdf_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the input transaction, restart the scan
    logic scan;    // issue the next store read, compare the previous one
    logic finish;  // write the result, update the store and its count
  } sdf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // match found or every stored entry compared
    logic out_free;   // output register empty or being taken this cycle
  } sdf_status_t;

endpackage

// ===== rtl/sdf_if.sv =====
// Valid/ready stream interfaces for the input and result channels of the
// stream duplicate filter. Depends on sdf_pkg.
interface sdf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdf_pkg::DataW-1:0]  value;
  logic                              end_of_set;

  modport source (output valid, output value, output end_of_set, input ready);
  modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

interface sdf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdf_pkg::DataW-1:0]  value_out;
  logic                              keep;
  logic                              overflow;
  logic                              last_out;

  modport source (output valid, output value_out, output keep, output overflow,
                  output last_out, input ready);
  modport sink   (input valid, input value_out, input keep, input overflow,
                  input last_out, output ready);
endinterface

// ===== rtl/sdf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module sdf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sdf_ctrl.sv =====
// Controller state machine of the stream duplicate filter: sequences load,
// store scan and result write. Depends on sdf_pkg.
module sdf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sdf_pkg::sdf_status_t status_i,
  output sdf_pkg::sdf_cmd_t    cmd_o
);
  import sdf_pkg::*;

  sdf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (status_i.scan_done) begin
          state_d = StFinish;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      StFinish: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== rtl/sdf_datapath.sv =====
// Datapath of the stream duplicate filter: input capture, store of seen
// values with its count, scan compare and output register.
// Depends on sdf_pkg and sdf_ram.
module sdf_datapath #(
  parameter int unsigned Capacity = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sdf_pkg::sdf_cmd_t               cmd_i,
  output sdf_pkg::sdf_status_t            status_o,
  input  logic signed [sdf_pkg::DataW-1:0] value_i,
  input  logic                            end_of_set_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [sdf_pkg::DataW-1:0] value_out_o,
  output logic                            keep_o,
  output logic                            overflow_o,
  output logic                            last_out_o
);
  import sdf_pkg::*;

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Capacity);

  // current transaction
  logic signed [DataW-1:0] val_q;
  logic                    last_q;

  // scan state
  logic [CntW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic            hit_q, hit_d;
  logic [CntW-1:0] count_q, count_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] out_val_q;
  logic                    out_keep_q, out_ovf_q, out_last_q;

  logic             issue;
  logic             is_new;
  logic             full;
  logic             store_we;
  logic [DataW-1:0] rdata;

  assign issue    = cmd_i.scan && !hit_q && (idx_q != count_q);
  assign is_new   = !hit_q;
  assign full     = (count_q == CntFull);
  assign store_we = cmd_i.finish && is_new && !full;

  sdf_ram #(
    .Width (DataW),
    .Depth (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (val_q),
    .re_i    (issue),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    idx_d   = idx_q;
    pend_d  = pend_q;
    hit_d   = hit_q;
    count_d = count_q;
    if (cmd_i.load) begin
      idx_d  = '0;
      pend_d = 1'b0;
      hit_d  = 1'b0;
    end else if (cmd_i.scan) begin
      idx_d  = idx_q + CntW'(issue);
      pend_d = issue;
      if (pend_q && (rdata == val_q)) begin
        hit_d = 1'b1;
      end
    end
    if (cmd_i.finish) begin
      // the last element of a set empties the store for the next set
      if (last_q) begin
        count_d = '0;
      end else if (store_we) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q  <= value_i;
      last_q <= end_of_set_i;
    end
    if (cmd_i.finish) begin
      out_val_q  <= val_q;
      out_keep_q <= is_new;
      out_ovf_q  <= is_new && full;
      out_last_q <= last_q;
    end
  end

  assign status_o.scan_done = hit_q || ((idx_q == count_q) && !pend_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_val_q;
  assign keep_o      = out_keep_q;
  assign overflow_o  = out_ovf_q;
  assign last_out_o  = out_last_q;

endmodule

// ===== rtl/stream_duplicate_filter.sv =====
// Stream duplicate filter: passes each signed 32-bit value with keep set only
// at its first occurrence within a set; the transaction marked end_of_set
// empties the store afterwards. Every input transaction gives exactly one
// result. A new value that meets a full store (CAPACITY entries) comes out
// with keep and overflow set and is not stored. The seen values sit in a
// RAM that is scanned one entry per cycle; the scan stops at the first
// matching entry. The result waits while the output register still holds
// a result that has not been taken. The output register holds a finished
// result while the next transaction is accepted. No clearing pass is
// needed after reset.
// Depends on sdf_pkg, sdf_if, sdf_ctrl and sdf_datapath.
module stream_duplicate_filter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdf_in_if.sink    in_i,
  sdf_out_if.source out_o
);
  import sdf_pkg::*;

  sdf_cmd_t    cmd;
  sdf_status_t status;

  sdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sdf_datapath #(
    .Capacity (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (in_i.value),
    .end_of_set_i (in_i.end_of_set),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .value_out_o  (out_o.value_out),
    .keep_o       (out_o.keep),
    .overflow_o   (out_o.overflow),
    .last_out_o   (out_o.last_out)
  );

endmodule

// ===== tb/sv/stream_duplicate_filter_checker.sv =====
`timescale 1ns / 1ps
// Checker for the stream duplicate filter: watches both channels, predicts each
// result from its own copy of the seen-value store and compares in order.
// Depends on sdf_pkg and sdf_if.
module stream_duplicate_filter_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  sdf_in_if    in_i,
  sdf_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);

  import sdf_pkg::DataW;

  typedef struct packed {
    logic signed [DataW-1:0] value_out;
    logic                    keep;
    logic                    overflow;
    logic                    last_out;
  } filter_result_t;

  logic [DataW-1:0] seen_store [CAPACITY];
  int unsigned      seen_total;
  filter_result_t   expected_results [$];

  function automatic filter_result_t predict_filter_result(input logic [DataW-1:0] v,
                                                           input logic eos);
    filter_result_t r;
    logic           found;
    found = 1'b0;
    for (int unsigned i = 0; i < seen_total; i++) begin
      if (seen_store[i] == v) found = 1'b1;
    end
    r.value_out = v;
    r.keep      = !found;
    r.overflow  = 1'b0;
    r.last_out  = eos;
    if (!found) begin
      if (seen_total < CAPACITY) begin
        seen_store[seen_total] = v;
        seen_total++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    // the last transaction of a set empties the store after it is handled
    if (eos) seen_total = 0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_result_t exp_r;
    if (!rst_ni) begin
      seen_total = 0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction waiting: value_out %0d",
                 $signed(out_i.value_out));
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_i.value_out !== exp_r.value_out) begin
            $error("value_out mismatch: expected %0d, actual %0d",
                   exp_r.value_out, $signed(out_i.value_out));
            fail_count_o++;
          end
          if (out_i.keep !== exp_r.keep) begin
            $error("keep mismatch: expected %0b, actual %0b", exp_r.keep, out_i.keep);
            fail_count_o++;
          end
          if (out_i.overflow !== exp_r.overflow) begin
            $error("overflow mismatch: expected %0b, actual %0b",
                   exp_r.overflow, out_i.overflow);
            fail_count_o++;
          end
          if (out_i.last_out !== exp_r.last_out) begin
            $error("last_out mismatch: expected %0b, actual %0b",
                   exp_r.last_out, out_i.last_out);
            fail_count_o++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        expected_results.push_back(predict_filter_result(in_i.value, in_i.end_of_set));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== tb/sv/stream_duplicate_filter_tb.sv =====
`timescale 1ns / 1ps
// Top of the stream duplicate filter testbench: clock, reset, stimulus, result
// back-pressure, watchdog and verdict. Depends on sdf_pkg, sdf_if, the filter
// RTL and stream_duplicate_filter_checker.
module stream_duplicate_filter_tb;

  localparam int unsigned Capacity    = 64;
  localparam int unsigned ItemTarget  = 1850;
  localparam int unsigned TailStart   = 1700;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 2 * Capacity + 16;

  logic clk_i;
  logic rst_ni;

  sdf_in_if  in_ch ();
  sdf_out_if out_ch ();

  int          fail_count;
  int          pending;
  int unsigned items_sent;
  int unsigned gap_free_left;
  int unsigned quiet_cycles;
  bit          tail_phase;
  bit          long_hold_req;
  bit          ready_held;

  stream_duplicate_filter #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  stream_duplicate_filter_checker #(
    .CAPACITY(Capacity)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // end the run when no transaction moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("stream_duplicate_filter regression: fail");
      $finish;
    end
  end

  // result back-pressure: random stall bursts, long ready stretches, one long hold
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_req && !tail_phase) begin
        long_hold_req = 1'b0;
        ready_held    = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        ready_held = 1'b0;
      end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(100, 300) : $urandom_range(1, 30))
          @(posedge clk_i);
      end
    end
  end

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(0, 7) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // offer one transaction and hold it until accepted; valid stays high on return
  task automatic offer_value(input logic [31:0] v, input logic eos);
    if (!tail_phase && !ready_held && gap_free_left == 0 && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    if (gap_free_left > 0) begin
      gap_free_left--;
    end else if ($urandom_range(0, 99) == 0) begin
      gap_free_left = $urandom_range(50, 150);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value      <= v;
    in_ch.end_of_set <= eos;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // lower valid and wait until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // few distinct values with many repeats, including one-bit near misses
  task automatic send_repeat_set();
    logic [31:0] pool [8];
    int unsigned pool_n;
    int unsigned len;
    pool_n = $urandom_range(1, 8);
    for (int unsigned k = 0; k < pool_n; k++) begin
      pool[k] = random_value();
      if (k > 0 && $urandom_range(0, 3) == 0) pool[k] = pool[0] ^ (32'd1 << $urandom_range(0, 31));
    end
    len = $urandom_range(1, 24);
    for (int unsigned k = 0; k < len; k++) begin
      offer_value(pool[$urandom_range(0, pool_n - 1)], k == len - 1);
    end
  endtask

  // distinct values around the store's capacity, then repeat the first and the newest value
  task automatic send_crowded_set(input int unsigned distinct_n);
    logic [31:0] base;
    logic [31:0] stride;
    logic [31:0] v;
    logic [31:0] used [$];
    int unsigned made;
    base   = $urandom;
    stride = $urandom | 32'd1;
    made   = 0;
    while (made < distinct_n) begin
      if (used.size() > 0 && $urandom_range(0, 3) == 0) begin
        v = used[$urandom_range(0, used.size() - 1)];
      end else begin
        v = base + made * stride;
        used.push_back(v);
        made++;
      end
      offer_value(v, 1'b0);
    end
    offer_value(used[0], 1'b0);
    offer_value(used[used.size() - 1], 1'b1);
  endtask

  // unstructured values with end_of_set at random
  task automatic send_noise_run();
    int unsigned len;
    len = $urandom_range(1, 10);
    repeat (len) offer_value(random_value(), $urandom_range(0, 1));
  endtask

  initial begin
    int unsigned pick;
    bit          drained_once;
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.value      <= '0;
    in_ch.end_of_set <= 1'b0;
    items_sent    = 0;
    gap_free_left = 0;
    tail_phase    = 1'b0;
    long_hold_req = 1'b0;
    ready_held    = 1'b0;
    drained_once  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes and repeats; the set ends on a repeated value
    offer_value(32'h8000_0000, 1'b0);
    offer_value(32'h7fff_ffff, 1'b0);
    offer_value(32'h0000_0000, 1'b0);
    offer_value(32'hffff_ffff, 1'b0);
    offer_value(32'h8000_0000, 1'b0);
    offer_value(32'h7fff_ffff, 1'b0);
    offer_value(32'h7fff_fffe, 1'b0);
    offer_value(32'h0000_0000, 1'b0);
    offer_value(32'hffff_ffff, 1'b1);
    // store cleared: old values are new again; the set ends on a new value
    offer_value(32'h0000_0000, 1'b0);
    offer_value(32'h0000_0000, 1'b0);
    offer_value(32'h0000_0001, 1'b0);
    offer_value(32'h0000_0001, 1'b0);
    offer_value(32'h8000_0001, 1'b0);
    offer_value(32'h8000_0000, 1'b1);
    // one-element sets
    offer_value(32'd42, 1'b1);
    offer_value(32'd42, 1'b1);
    // full store: overflowed value flagged again on repeat
    send_crowded_set(Capacity + 2);

    long_hold_req = 1'b1;
    while (items_sent < ItemTarget) begin
      if (items_sent >= TailStart) tail_phase = 1'b1;
      if (!drained_once && items_sent >= ItemTarget / 2) begin
        drained_once = 1'b1;
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_crowded_set($urandom_range(Capacity - 8, Capacity + 8));
      end else if (pick < 85) begin
        send_repeat_set();
      end else begin
        send_noise_run();
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("stream_duplicate_filter regression: pass");
    end else begin
      $display("stream_duplicate_filter regression: fail");
    end
    $finish;
  end

endmodule
